// ===== rtl/kdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce / long-press block.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

   // field widths
   localparam int KeyBits   = 6;
   localparam int IndexBits = 3;
   localparam int DebBits   = 8;
   localparam int TickBits  = 16;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 16;

   // number of keys on the board; only keys that also fit the input word are scanned
   localparam int NumKeys  = 6;
   localparam int ScanKeys = (NumKeys < KeyBits) ? NumKeys : KeyBits;

   // register reset values
   localparam logic [DebBits-1:0]  DebounceReset = 8'd10;
   localparam logic [TickBits-1:0] LongReset     = 16'd1000;
   localparam logic [KeyBits-1:0]  MaskReset     = 6'd48;

   localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

   // register indexes
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_LONG_TICKS     = 2'd1,
      CSR_LONG_KEY_MASK  = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HELD     = 2'd2
   } phase_type;

   typedef struct packed {
      logic [DebBits-1:0]  debounce_ticks;
      logic [TickBits-1:0] long_ticks;
      logic [KeyBits-1:0]  long_key_mask;
   } cfg_type;

   typedef struct packed {
      logic      take;
      phase_type phase;
   } fsm_stat_type;

endpackage

`default_nettype wire

// ===== rtl/kdlp_csr.sv =====
// ----------------------------------------------------------------------------
// kdlp_csr
// Configuration registers: index decode and storage.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [kdlp_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [kdlp_pkg::CsrDataBits-1:0]    csr_wdata,
   output kdlp_pkg::cfg_type                        cfg
);

   kdlp_pkg::cfg_type cfg_ff;
   kdlp_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            kdlp_pkg::CSR_DEBOUNCE_TICKS:
               cfg_in.debounce_ticks = csr_wdata[kdlp_pkg::DebBits-1:0];
            kdlp_pkg::CSR_LONG_TICKS:
               cfg_in.long_ticks = csr_wdata[kdlp_pkg::TickBits-1:0];
            kdlp_pkg::CSR_LONG_KEY_MASK:
               cfg_in.long_key_mask = csr_wdata[kdlp_pkg::KeyBits-1:0];
            default: begin
               // write beyond the register list is dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= kdlp_pkg::DebounceReset;
         cfg_ff.long_ticks     <= kdlp_pkg::LongReset;
         cfg_ff.long_key_mask  <= kdlp_pkg::MaskReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kdlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// kdlp_in_stage
// Input register for one tick of key state.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_in_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [kdlp_pkg::KeyBits-1:0]     req_keys_pressed,
   input  wire logic                             take,
   output logic                                  item_valid,
   output logic [kdlp_pkg::KeyBits-1:0]          item_keys
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [kdlp_pkg::KeyBits-1:0]   keys_ff;

   // a slot frees up in the same cycle the held item is consumed
   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item_keys  = keys_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         keys_ff <= req_keys_pressed;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kdlp_fsm.sv =====
// ----------------------------------------------------------------------------
// kdlp_fsm
// Debounce / hold state machine, tick counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_fsm (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire kdlp_pkg::cfg_type                 cfg,
   input  wire logic                              item_valid,
   input  wire logic [kdlp_pkg::KeyBits-1:0]      item_keys,
   output kdlp_pkg::fsm_stat_type                 stat,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [kdlp_pkg::IndexBits-1:0]         rsp_key_index,
   output logic                                   rsp_long_press
);

   kdlp_pkg::phase_type                phase_ff;
   kdlp_pkg::phase_type                phase_in;
   logic [kdlp_pkg::IndexBits-1:0]     active_ff;
   logic [kdlp_pkg::IndexBits-1:0]     active_in;
   logic [kdlp_pkg::TickBits-1:0]      tick_ff;
   logic [kdlp_pkg::TickBits-1:0]      tick_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [kdlp_pkg::IndexBits-1:0]     key_index_ff;
   logic                               long_press_ff;

   logic                               take;
   logic                               emit;
   logic                               emit_long;
   logic                               down;
   logic [kdlp_pkg::TickBits-1:0]      tick_inc;

   // an item moves on whenever the result slot is free or being drained
   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   assign down     = (active_ff < kdlp_pkg::IndexBits'(kdlp_pkg::KeyBits)) ?
                     item_keys[active_ff] : 1'b0;
   assign tick_inc = (tick_ff == kdlp_pkg::TickMax) ? kdlp_pkg::TickMax
                                                    : tick_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      tick_in   = tick_ff;
      emit      = 1'b0;
      emit_long = 1'b0;
      if (take) begin
         case (phase_ff)
            kdlp_pkg::PH_DEBOUNCE: begin
               tick_in = tick_inc;
               if (tick_inc >= {{(kdlp_pkg::TickBits-kdlp_pkg::DebBits){1'b0}},
                                cfg.debounce_ticks}) begin
                  phase_in = down ? kdlp_pkg::PH_HELD : kdlp_pkg::PH_IDLE;
               end
            end
            kdlp_pkg::PH_HELD: begin
               tick_in = tick_inc;
               if (!down) begin
                  emit      = 1'b1;
                  emit_long = cfg.long_key_mask[active_ff] &&
                              (tick_inc >= cfg.long_ticks);
                  phase_in  = kdlp_pkg::PH_IDLE;
               end
            end
            default: begin
               // idle and the unused code: pick the lowest pressed key
               phase_in = kdlp_pkg::PH_IDLE;
               for (int i = kdlp_pkg::ScanKeys - 1; i >= 0; i--) begin
                  if (item_keys[i]) begin
                     active_in = kdlp_pkg::IndexBits'(i);
                     tick_in   = '0;
                     phase_in  = kdlp_pkg::PH_DEBOUNCE;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= kdlp_pkg::PH_IDLE;
         active_ff    <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         key_index_ff  <= active_ff;
         long_press_ff <= emit_long;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_index  = key_index_ff;
   assign rsp_long_press = long_press_ff;
   assign stat.take      = take;
   assign stat.phase     = phase_ff;

endmodule

`default_nettype wire

// ===== rtl/key_debounce_long_press_top.sv =====
// ----------------------------------------------------------------------------
// key_debounce_long_press_top
// Six-key debouncer with release reporting and long-press classification.
// ----------------------------------------------------------------------------
//  channel | ports                               | transfer when
//  --------+-------------------------------------+----------------------------
//  req     | req_keys_pressed[5:0]               | req_valid && req_ready
//  rsp     | rsp_key_index[2:0], rsp_long_press  | rsp_valid && rsp_ready
//  csr     | csr_index[1:0], csr_wdata[15:0]     | csr_valid (csr_ready is 1)
//
//  one tick per clock while rsp is not stalled; a tick goes through the input
//  register and then the state update, and a release shows on rsp from the
//  result register. while a result waits, the next tick may enter the input
//  register but is not consumed until the result register drains, so a stall
//  on rsp holds req_ready low. reset returns to idle and restores defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_long_press_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [kdlp_pkg::KeyBits-1:0]        req_keys_pressed,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [kdlp_pkg::IndexBits-1:0]           rsp_key_index,
   output logic                                     rsp_long_press,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [kdlp_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [kdlp_pkg::CsrDataBits-1:0]    csr_wdata
);

   kdlp_pkg::cfg_type               cfg;
   kdlp_pkg::fsm_stat_type          stat;
   logic                            item_valid;
   logic [kdlp_pkg::KeyBits-1:0]    item_keys;

   kdlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kdlp_in_stage u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_keys_pressed (req_keys_pressed),
      .take             (stat.take),
      .item_valid       (item_valid),
      .item_keys        (item_keys)
   );

   kdlp_fsm u_fsm (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .item_valid     (item_valid),
      .item_keys      (item_keys),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_index  (rsp_key_index),
      .rsp_long_press (rsp_long_press)
   );

   // a new result only comes from a tick consumed in the held phase
   a_rsp_from_held: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(stat.take) && $past(stat.phase) == kdlp_pkg::PH_HELD))
      else $error("result raised outside a held release");

   // a waiting result is never overwritten by a tick in the held phase
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && stat.phase == kdlp_pkg::PH_HELD) |-> !stat.take)
      else $error("held tick consumed while result stalled");

   // idle never jumps straight to held without a debounce pass
   a_idle_to_held: assert property (@(posedge clock) disable iff (reset)
      (stat.phase == kdlp_pkg::PH_IDLE) |=> (stat.phase != kdlp_pkg::PH_HELD))
      else $error("held entered without debounce");

endmodule

`default_nettype wire
